[rtl/imm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_pkg: shared types and constants for the frame statistics unit
// Frame size limits, field widths, bounding helper and controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 13;
  localparam int COUNT_W = 25;
  localparam int SUM_W   = 32;
  localparam int STEP_W  = 3;

  localparam logic [SIZE_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [SIZE_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  // Register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Clamp a size register into 1..hi
  function automatic logic [SIZE_W-1:0] bound_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = {{(SIZE_W-1){1'b0}}, 1'b1};
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Pixel count of a frame from the two bounded sizes
  function automatic logic [COUNT_W-1:0] frame_pixels(input logic [SIZE_W-1:0] w,
                                                      input logic [SIZE_W-1:0] h);
    logic [2*SIZE_W-1:0] prod;
    prod = bound_size(w, MAX_WIDTH) * bound_size(h, MAX_HEIGHT);
    return prod[COUNT_W-1:0];
  endfunction

  typedef struct packed {
    logic accum_en;  // take the accepted pixel into the running stats
    logic prep;      // latch dividend and divisor, clear running stats
    logic div_step;  // one restoring division step
    logic load_out;  // move the finished result into the output register
  } imm_cmd_t;

  typedef struct packed {
    logic frame_end; // this pixel completes the frame
    logic out_free;  // output register can take a new word
  } imm_status_t;

endpackage

[rtl/image_min_max_mean_unit.sv]
`timescale 1ns / 1ps
// Result path: after the last pixel of a frame the unit runs a preparation state,
//   8 restoring division steps and a hand-off state into the output register.
// Throughput: one pixel per cycle within a frame; between frames pixels are
//   stalled while the divider runs and until the output register takes the word.
// Reset: sizes return to 4096 x 4096, running stats clear, no word pending.
// ----------------------------------------------------------------------------
// image_min_max_mean_unit: 8-bit image min, max and rounded mean
// Streams pixels, reports min, max and (sum + n/2) / n at each frame end.
// ----------------------------------------------------------------------------
module image_min_max_mean_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [imm_pkg::PIX_W-1:0]  pixel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [imm_pkg::PIX_W-1:0]  min_value,
  output logic [imm_pkg::PIX_W-1:0]  max_value,
  output logic [imm_pkg::PIX_W-1:0]  mean_value
);

  logic [imm_pkg::SIZE_W-1:0]  image_width;
  logic [imm_pkg::SIZE_W-1:0]  image_height;
  logic [imm_pkg::COUNT_W-1:0] frame_size;
  logic [imm_pkg::SIZE_W-1:0]  wr_value;
  logic                        wr_en;
  logic                        reg_sel;
  imm_pkg::imm_cmd_t           cmd;
  imm_pkg::imm_status_t        status;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_sel  = paddr[2];
  assign wr_value = pwdata[imm_pkg::SIZE_W-1:0];

  // Read back the addressed size register
  always_comb begin
    unique case (reg_sel)
      imm_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      imm_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:                   prdata = '0;
    endcase
  end

  // Size registers; frame size is recomputed on every write
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= imm_pkg::SIZE_RESET;
      image_height <= imm_pkg::SIZE_RESET;
      frame_size   <= imm_pkg::frame_pixels(imm_pkg::SIZE_RESET, imm_pkg::SIZE_RESET);
    end else if (wr_en) begin
      if (reg_sel == imm_pkg::REG_IMAGE_WIDTH) begin
        image_width <= wr_value;
        frame_size  <= imm_pkg::frame_pixels(wr_value, image_height);
      end else begin
        image_height <= wr_value;
        frame_size   <= imm_pkg::frame_pixels(image_width, wr_value);
      end
    end
  end

  imm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  imm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .frame_size (frame_size),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .min_value  (min_value),
    .max_value  (max_value),
    .mean_value (mean_value)
  );

endmodule

[rtl/imm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_ctrl: frame statistics controller
// Sequences accumulation, dividend preparation, the eight division steps and
// the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module imm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  imm_pkg::imm_status_t status,
  output imm_pkg::imm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_ACCUM  = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } imm_state_t;

  imm_state_t                  state;
  imm_state_t                  state_next;
  logic [imm_pkg::STEP_W-1:0]  step;
  logic [imm_pkg::STEP_W-1:0]  step_next;

  // Take pixels only while accumulating
  assign in_stall = (state != ST_ACCUM);

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    unique case (state)
      ST_ACCUM: begin
        cmd.accum_en = in_valid;
        if (in_valid && status.frame_end) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == '1) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

[rtl/imm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_dp: frame statistics datapath
// Running min/max/sum/count, a restoring divider for the rounded mean and the
// output register.
// ----------------------------------------------------------------------------
module imm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [imm_pkg::PIX_W-1:0]     pixel,
  input  logic [imm_pkg::COUNT_W-1:0]   frame_size,
  input  imm_pkg::imm_cmd_t             cmd,
  output imm_pkg::imm_status_t          status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [imm_pkg::PIX_W-1:0]     min_value,
  output logic [imm_pkg::PIX_W-1:0]     max_value,
  output logic [imm_pkg::PIX_W-1:0]     mean_value
);

  logic [imm_pkg::PIX_W-1:0]   run_min;
  logic [imm_pkg::PIX_W-1:0]   run_max;
  logic [imm_pkg::SUM_W-1:0]   run_sum;
  logic [imm_pkg::COUNT_W-1:0] run_count;
  logic [imm_pkg::COUNT_W-1:0] count_next;

  logic [imm_pkg::PIX_W-1:0]   hold_min;
  logic [imm_pkg::PIX_W-1:0]   hold_max;
  logic [imm_pkg::SUM_W-1:0]   rem;
  logic [imm_pkg::SUM_W-1:0]   divisor;
  logic [imm_pkg::PIX_W-1:0]   quot;
  logic                        fits;

  assign count_next       = run_count + 1'b1;
  assign status.frame_end = (count_next >= frame_size);
  assign status.out_free  = !out_valid || !out_stall;
  assign fits             = (rem >= divisor);

  // Accumulate pixels, clear once the frame is handed to the divider
  always_ff @(posedge clk) begin
    if (rst || cmd.prep) begin
      run_min   <= '1;
      run_max   <= '0;
      run_sum   <= '0;
      run_count <= '0;
    end else if (cmd.accum_en) begin
      if (pixel < run_min) begin
        run_min <= pixel;
      end
      if (pixel > run_max) begin
        run_max <= pixel;
      end
      run_sum   <= run_sum + imm_pkg::SUM_W'(pixel);
      run_count <= count_next;
    end
  end

  // Restoring division: (sum + n/2) / n, quotient known to fit in 8 bits
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      hold_min <= run_min;
      hold_max <= run_max;
      rem      <= run_sum + imm_pkg::SUM_W'(run_count >> 1);
      divisor  <= imm_pkg::SUM_W'(run_count) << (imm_pkg::PIX_W - 1);
      quot     <= '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem <= rem - divisor;
      end
      divisor <= divisor >> 1;
      quot    <= {quot[imm_pkg::PIX_W-2:0], fits};
    end
  end

  // Output register: flag under reset, word loaded on hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      min_value  <= hold_min;
      max_value  <= hold_max;
      mean_value <= quot;
    end
  end

endmodule

[dv/image_min_max_mean_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_min_max_mean_checker: frame statistics scoreboard
// Watches the configuration port and both streams, keeps its own copy of the
// frame size registers and the running min, max, sum and count, predicts one
// statistics word per completed frame and compares each output word with the
// oldest prediction. Register reads are checked against the written value.
// ----------------------------------------------------------------------------
module image_min_max_mean_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  input  logic [31:0]               prdata,
  input  logic                      pready,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [imm_pkg::PIX_W-1:0] pixel,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [imm_pkg::PIX_W-1:0] min_value,
  input  logic [imm_pkg::PIX_W-1:0] max_value,
  input  logic [imm_pkg::PIX_W-1:0] mean_value,
  output int                        frames_due,
  output int                        fail_count
);

  typedef struct packed {
    logic [imm_pkg::PIX_W-1:0] lo;
    logic [imm_pkg::PIX_W-1:0] hi;
    logic [imm_pkg::PIX_W-1:0] avg;
  } frame_stats_t;

  frame_stats_t                frame_stats_q[$];
  logic [imm_pkg::SIZE_W-1:0]  width_reg;
  logic [imm_pkg::SIZE_W-1:0]  height_reg;
  logic [imm_pkg::PIX_W-1:0]   run_min;
  logic [imm_pkg::PIX_W-1:0]   run_max;
  logic [imm_pkg::SUM_W-1:0]   run_sum;
  logic [imm_pkg::COUNT_W-1:0] run_count;

  initial begin
    frames_due = 0;
    fail_count = 0;
  end

  // Zero reads as one, anything past the limit saturates
  function automatic logic [imm_pkg::SIZE_W-1:0] clamp_dim(
      input logic [imm_pkg::SIZE_W-1:0] v,
      input logic [imm_pkg::SIZE_W-1:0] lim);
    return (v == '0) ? imm_pkg::SIZE_W'(1) : ((v > lim) ? lim : v);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_frame();
    run_min   = '1;
    run_max   = '0;
    run_sum   = '0;
    run_count = '0;
  endtask

  // Fold one accepted pixel into the running stats, close the frame if full
  task automatic fold_pixel(input logic [imm_pkg::PIX_W-1:0] p);
    logic [2*imm_pkg::SIZE_W-1:0] frame_len;
    logic [63:0]                  total;
    logic [63:0]                  quotient;
    frame_stats_t                 s;
    if (p < run_min) run_min = p;
    if (p > run_max) run_max = p;
    run_sum   = run_sum + imm_pkg::SUM_W'(p);
    run_count = run_count + 1'b1;
    frame_len = clamp_dim(width_reg, imm_pkg::MAX_WIDTH) *
                clamp_dim(height_reg, imm_pkg::MAX_HEIGHT);
    if ({1'b0, run_count} >= frame_len) begin
      total    = 64'(run_sum) + 64'(run_count >> 1);
      quotient = total / 64'(run_count);
      s.lo  = run_min;
      s.hi  = run_max;
      s.avg = quotient[imm_pkg::PIX_W-1:0];
      frame_stats_q.push_back(s);
      frames_due++;
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    frame_stats_t got_s;
    if (rst) begin
      width_reg  = imm_pkg::SIZE_RESET;
      height_reg = imm_pkg::SIZE_RESET;
      clear_frame();
      frame_stats_q.delete();
      frames_due = 0;
    end else begin
      // Compare each delivered word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (frame_stats_q.size() == 0) begin
          flag_mismatch("word with no frame pending", 1, 0);
        end else begin
          got_s = frame_stats_q.pop_front();
          frames_due--;
          if (min_value !== got_s.lo)
            flag_mismatch("min_value", int'(min_value), int'(got_s.lo));
          if (max_value !== got_s.hi)
            flag_mismatch("max_value", int'(max_value), int'(got_s.hi));
          if (mean_value !== got_s.avg)
            flag_mismatch("mean_value", int'(mean_value), int'(got_s.avg));
        end
      end
      // Track register writes, check register reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == imm_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = pwdata[imm_pkg::SIZE_W-1:0];
          end else begin
            width_reg = pwdata[imm_pkg::SIZE_W-1:0];
          end
        end else if (paddr[2] == imm_pkg::REG_IMAGE_HEIGHT) begin
          if (prdata[imm_pkg::SIZE_W-1:0] !== height_reg)
            flag_mismatch("image_height read", int'(prdata[imm_pkg::SIZE_W-1:0]),
                          int'(height_reg));
        end else begin
          if (prdata[imm_pkg::SIZE_W-1:0] !== width_reg)
            flag_mismatch("image_width read", int'(prdata[imm_pkg::SIZE_W-1:0]),
                          int'(width_reg));
        end
      end
      // Predict from each accepted pixel word
      if (in_valid && !in_stall) begin
        fold_pixel(pixel);
      end
    end
  end

endmodule

[dv/image_min_max_mean_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_min_max_mean_unit_test: stimulus and verdict for the frame stats unit
// Programs frame sizes over the register port (zero, small, saturating and
// mid-frame changes), streams pixel frames with random idle and stall bursts,
// and lets the checker score every statistics word.
// ----------------------------------------------------------------------------
module image_min_max_mean_unit_test;

  localparam int RANDOM_ITEMS  = 1300;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 30;
  localparam int LIMIT_CYCLES  = 2000000;

  typedef enum logic [1:0] {PIX_UNIFORM, PIX_FLAT, PIX_DARK, PIX_BRIGHT} pix_style_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_stall;
  logic [imm_pkg::PIX_W-1:0]  pixel;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [imm_pkg::PIX_W-1:0]  min_value;
  logic [imm_pkg::PIX_W-1:0]  max_value;
  logic [imm_pkg::PIX_W-1:0]  mean_value;
  int                         frames_due;
  int                         fail_count;

  logic                       quiet = 1'b0;
  logic                       calm = 1'b0;
  int                         stall_left = 0;
  int                         cycles = 0;
  int                         fed = 0;
  int                         fill = 0;
  int                         target = 1;
  logic [imm_pkg::SIZE_W-1:0] width_set = imm_pkg::SIZE_RESET;
  logic [imm_pkg::SIZE_W-1:0] height_set = imm_pkg::SIZE_RESET;

  image_min_max_mean_unit DUT (.*);

  image_min_max_mean_checker stats_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up well past the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL image_min_max_mean_unit");
      $finish;
    end
  end

  // Output back-pressure in random bursts
  always @(negedge clk) begin
    if (quiet || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int frame_len(input logic [imm_pkg::SIZE_W-1:0] w,
                                   input logic [imm_pkg::SIZE_W-1:0] h);
    int wd;
    int ht;
    wd = (w == '0) ? 1 : ((w > imm_pkg::MAX_WIDTH) ? int'(imm_pkg::MAX_WIDTH) : int'(w));
    ht = (h == '0) ? 1 : ((h > imm_pkg::MAX_HEIGHT) ? int'(imm_pkg::MAX_HEIGHT) : int'(h));
    return wd * ht;
  endfunction

  function automatic logic [imm_pkg::PIX_W-1:0] pick_pixel(
      input pix_style_t style,
      input logic [imm_pkg::PIX_W-1:0] base);
    unique case (style)
      PIX_FLAT:   return base;
      PIX_DARK:   return imm_pkg::PIX_W'($urandom_range(0, 3));
      PIX_BRIGHT: return imm_pkg::PIX_W'($urandom_range(252, 255));
      default:    return imm_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one pixel word, with an occasional idle burst in front
  task automatic feed_pixel(input logic [imm_pkg::PIX_W-1:0] value);
    int gap;
    @(negedge clk);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fed++;
    fill++;
    if (fill >= target) fill = 0;
  endtask

  task automatic feed_run(input int n, input pix_style_t style);
    logic [imm_pkg::PIX_W-1:0] base;
    base = imm_pkg::PIX_W'($urandom_range(0, 255));
    repeat (n) feed_pixel(pick_pixel(style, base));
  endtask

  // Drop valid, wait for every pending word, then let the divider settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write with random junk above the 13-bit field
  task automatic write_size(input logic idx, input logic [imm_pkg::SIZE_W-1:0] value);
    logic [31:0] word;
    word = $urandom();
    word[imm_pkg::SIZE_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == imm_pkg::REG_IMAGE_HEIGHT) height_set = value;
    else width_set = value;
    target = frame_len(width_set, height_set);
  endtask

  task automatic read_size(input logic idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_size(input logic [imm_pkg::SIZE_W-1:0] w,
                          input logic [imm_pkg::SIZE_W-1:0] h);
    write_size(imm_pkg::REG_IMAGE_WIDTH, w);
    write_size(imm_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  initial begin : stimulus
    int                         base_fed;
    int                         frames;
    int                         span;
    logic                       cut;
    logic [imm_pkg::SIZE_W-1:0] w;
    logic [imm_pkg::SIZE_W-1:0] h;
    pix_style_t                 style;

    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    pixel    = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Zero sizes act as one pixel per frame
    set_size(13'd0, 13'd0);
    read_size(imm_pkg::REG_IMAGE_WIDTH);
    read_size(imm_pkg::REG_IMAGE_HEIGHT);
    feed_pixel(8'd0);
    feed_pixel(8'd255);
    feed_pixel(8'd128);

    // Rounding at half, both ends of the pixel range
    wait_drained();
    set_size(13'd2, 13'd1);
    feed_pixel(8'd0);
    feed_pixel(8'd1);
    feed_pixel(8'd255);
    feed_pixel(8'd254);
    wait_drained();
    write_size(imm_pkg::REG_IMAGE_WIDTH, 13'd3);
    feed_pixel(8'd1);
    feed_pixel(8'd0);
    feed_pixel(8'd0);
    feed_pixel(8'd2);
    feed_pixel(8'd0);
    feed_pixel(8'd0);

    // Shrink the frame below the pixels already counted
    wait_drained();
    set_size(13'd4, 13'd4);
    feed_run(5, PIX_UNIFORM);
    wait_drained();
    set_size(13'd1, 13'd2);
    feed_pixel(8'd60);

    // Grow the frame in the middle
    wait_drained();
    write_size(imm_pkg::REG_IMAGE_WIDTH, 13'd2);
    feed_pixel(8'd7);
    wait_drained();
    write_size(imm_pkg::REG_IMAGE_WIDTH, 13'd3);
    feed_pixel(8'd9);
    feed_pixel(8'd11);

    // Saturating sizes hold a partial frame open, a small size closes it
    wait_drained();
    set_size(13'h1FFF, 13'd1);
    read_size(imm_pkg::REG_IMAGE_WIDTH);
    feed_run(20, PIX_UNIFORM);
    wait_drained();
    set_size(13'h1FFF, 13'h1FFF);
    feed_run(20, PIX_DARK);
    wait_drained();
    set_size(13'd1, 13'd1);
    feed_pixel(8'd200);

    // Random sizes and frames, some cut short before a size change
    base_fed = fed;
    while (fed - base_fed < RANDOM_ITEMS) begin
      wait_drained();
      quiet = (fed - base_fed >= RANDOM_ITEMS - QUIET_TAIL);
      calm  = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) == 0) ? imm_pkg::SIZE_W'($urandom_range(10, 40))
                                     : imm_pkg::SIZE_W'($urandom_range(0, 9));
      h = imm_pkg::SIZE_W'($urandom_range(0, 9));
      if ($urandom_range(0, 2) != 0) write_size(imm_pkg::REG_IMAGE_WIDTH, w);
      if ($urandom_range(0, 2) != 0) write_size(imm_pkg::REG_IMAGE_HEIGHT, h);
      if ($urandom_range(0, 7) == 0) read_size(logic'($urandom_range(0, 1)));
      frames = $urandom_range(1, 4);
      cut = 1'b0;
      for (int f = 0; f < frames && !cut; f++) begin
        style = pix_style_t'($urandom_range(0, 3));
        span  = target - fill;
        if (span > 1 && $urandom_range(0, 7) == 0) begin
          span = $urandom_range(1, span - 1);
          cut  = 1'b1;
        end
        feed_run(span, style);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS image_min_max_mean_unit");
    end else begin
      $display("FAIL image_min_max_mean_unit");
    end
    $finish;
  end

endmodule
